FILE: hdl/ffba_pkg.sv
// ---------------------------------------------------------------------------
// ffba_pkg: shared definitions for the first-fit block allocator
// Field widths, heap granule constants, request and status codes, and the
// sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  // Default heap size in bytes.
  localparam int HEAP_BYTES_DEF = 4096;

  // Heap granule is 16 bytes; every block header takes 8 bytes.
  localparam int GRAN_SHIFT   = 4;
  localparam int GRAN_BYTES   = 16;
  localparam int HDR_BYTES    = 8;

  // Fixed payload field widths.
  localparam int REQ_W  = 12;
  localparam int OFS_W  = 12;
  localparam int STAT_W = 2;
  // Width of a rounded-up request measured in granules.
  localparam int NEED_W = REQ_W + 1 - GRAN_SHIFT;

  // Payload offset of a block relative to its start, as the low bits.
  localparam logic [GRAN_SHIFT-1:0] HDR_OFS = GRAN_SHIFT'(HDR_BYTES);

  // Request codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_EVAL,
    S_A_SPLIT,
    S_F_EVAL,
    S_F_NEXT,
    S_F_PREV,
    S_F_CLEAR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/first_fit_block_allocator.sv
// An allocate walks the headers in S_A_EVAL, then passes S_A_SPLIT on a split
// and S_DONE; a free walks in S_F_EVAL, then passes S_F_NEXT, S_F_PREV,
// S_F_CLEAR when it merges with the previous block, and S_DONE. Requests are
// taken one at a time; the header walk reads one block header per cycle.
// Reset: no sweep; until entry zero is first written it reads as a
// single free block covering the whole heap.
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// Implicit free-list heap manager: first-fit allocate with split, and free
// with merging of free neighbors, walking the block headers in a memory.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
  parameter int HEAP_BYTES = ffba_pkg::HEAP_BYTES_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           req_valid,
  output logic                          req_stall,
  input  wire                           operation,
  input  wire [ffba_pkg::REQ_W-1:0]     request_bytes,
  input  wire [ffba_pkg::OFS_W-1:0]     free_offset,
  output logic                          rsp_valid,
  input  wire                           rsp_stall,
  output logic [ffba_pkg::STAT_W-1:0]   status,
  output logic [ffba_pkg::OFS_W-1:0]    granted_offset
);

  localparam int NG = HEAP_BYTES / ffba_pkg::GRAN_BYTES;
  localparam int IW = (NG > 1) ? $clog2(NG) : 1;
  localparam int GW = $clog2(NG + 1);
  localparam int HW = GW + 1;
  localparam int CW = (GW > ffba_pkg::NEED_W) ? GW : ffba_pkg::NEED_W;
  localparam int BW = (GW + ffba_pkg::GRAN_SHIFT > ffba_pkg::OFS_W) ?
                      GW + ffba_pkg::GRAN_SHIFT : ffba_pkg::OFS_W;
  localparam logic [GW-1:0] NG_G = GW'(NG);

  // Header store: {size in granules, allocated bit} at each block start.
  logic [HW-1:0] mem [NG];
  logic [HW-1:0] rd_data;
  logic          rd_fresh0;
  logic          init0;

  ffba_pkg::state_t state, state_next;
  logic [GW-1:0]    cur, cur_next;
  logic [GW-1:0]    prev, prev_next;
  logic [GW-1:0]    nx, nx_next;
  logic [GW-1:0]    size_cur, size_next;
  logic [ffba_pkg::NEED_W-1:0] need, need_next;
  logic [ffba_pkg::OFS_W-1:0]  off, off_next;
  logic [ffba_pkg::STAT_W-1:0] res_status, res_status_next;
  logic [ffba_pkg::OFS_W-1:0]  res_offset, res_offset_next;

  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [HW-1:0] mem_wdata;
  logic          load_rsp;

  logic [GW-1:0] hdr_g;
  logic          hdr_used;
  logic [GW-1:0] room;
  logic [GW-1:0] nxt;
  logic          fits;
  logic [GW-1:0] excess;
  logic [GW-1:0] split_idx;
  logic [BW-1:0] cur_ofs;
  logic          match;
  logic [ffba_pkg::REQ_W:0] req_sum;

  // Entry zero holds the whole heap as one free block until it is written.
  assign hdr_g    = rd_fresh0 ? NG_G : rd_data[HW-1:1];
  assign hdr_used = rd_fresh0 ? 1'b0 : rd_data[0];

  // Shared walk datapath: next block start, fit check, offset match.
  assign room    = NG_G - cur;
  assign nxt     = (hdr_g == '0 || hdr_g > room) ? NG_G : cur + hdr_g;
  assign fits    = !hdr_used && (CW'(need) <= CW'(hdr_g));
  assign excess  = hdr_g - GW'(need);
  assign split_idx = cur + GW'(need);
  assign cur_ofs = BW'({cur, ffba_pkg::HDR_OFS});
  assign match   = (cur_ofs == BW'(off));
  assign req_sum = {1'b0, request_bytes} +
                   (ffba_pkg::REQ_W+1)'(ffba_pkg::HDR_BYTES + ffba_pkg::GRAN_BYTES - 1);

  assign req_stall = (state != ffba_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init0     <= 1'b0;
      rd_fresh0 <= 1'b0;
    end else begin
      rd_fresh0 <= (rd_addr == '0) && !init0;
      if (mem_we && mem_waddr == '0) begin
        init0 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
    cur        <= cur_next;
    prev       <= prev_next;
    nx         <= nx_next;
    size_cur   <= size_next;
    need       <= need_next;
    off        <= off_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid      <= 1'b1;
      status         <= res_status;
      granted_offset <= res_offset;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    prev_next       = prev;
    nx_next         = nx;
    size_next       = size_cur;
    need_next       = need;
    off_next        = off;
    res_status_next = res_status;
    res_offset_next = res_offset;
    rd_addr         = cur[IW-1:0];
    mem_we          = 1'b0;
    mem_waddr       = cur[IW-1:0];
    mem_wdata       = '0;
    load_rsp        = 1'b0;
    case (state)
      ffba_pkg::S_IDLE: begin
        rd_addr = '0;
        if (req_valid) begin
          need_next       = req_sum[ffba_pkg::REQ_W:ffba_pkg::GRAN_SHIFT];
          off_next        = free_offset;
          cur_next        = '0;
          prev_next       = '0;
          res_offset_next = '0;
          state_next      = (operation == ffba_pkg::OP_FREE) ?
                            ffba_pkg::S_F_EVAL : ffba_pkg::S_A_EVAL;
        end
      end
      ffba_pkg::S_A_EVAL: begin
        if (fits) begin
          mem_we          = 1'b1;
          mem_wdata       = {(excess != '0) ? GW'(need) : hdr_g, 1'b1};
          res_status_next = ffba_pkg::ST_OK;
          res_offset_next = cur_ofs[ffba_pkg::OFS_W-1:0];
          size_next       = excess;
          state_next      = (excess != '0) ? ffba_pkg::S_A_SPLIT : ffba_pkg::S_DONE;
        end else if (nxt == NG_G) begin
          res_status_next = ffba_pkg::ST_NOFIT;
          state_next      = ffba_pkg::S_DONE;
        end else begin
          cur_next = nxt;
          rd_addr  = nxt[IW-1:0];
        end
      end
      ffba_pkg::S_A_SPLIT: begin
        // The remainder becomes a free block right after the granted one.
        mem_we     = 1'b1;
        mem_waddr  = split_idx[IW-1:0];
        mem_wdata  = {size_cur, 1'b0};
        state_next = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_F_EVAL: begin
        if (match) begin
          if (hdr_used) begin
            size_next  = hdr_g;
            nx_next    = nxt;
            rd_addr    = nxt[IW-1:0];
            state_next = ffba_pkg::S_F_NEXT;
          end else begin
            res_status_next = ffba_pkg::ST_BADFREE;
            state_next      = ffba_pkg::S_DONE;
          end
        end else if (nxt == NG_G) begin
          res_status_next = ffba_pkg::ST_BADFREE;
          state_next      = ffba_pkg::S_DONE;
        end else begin
          prev_next = cur;
          cur_next  = nxt;
          rd_addr   = nxt[IW-1:0];
        end
      end
      ffba_pkg::S_F_NEXT: begin
        // The header of the following block is on the read port now.
        if (nx != NG_G && !hdr_used) begin
          size_next = size_cur + hdr_g;
          mem_we    = 1'b1;
          mem_waddr = nx[IW-1:0];
          mem_wdata = '0;
        end
        rd_addr    = prev[IW-1:0];
        state_next = ffba_pkg::S_F_PREV;
      end
      ffba_pkg::S_F_PREV: begin
        res_status_next = ffba_pkg::ST_OK;
        mem_we          = 1'b1;
        if (prev != cur && !hdr_used) begin
          mem_waddr  = prev[IW-1:0];
          mem_wdata  = {hdr_g + size_cur, 1'b0};
          state_next = ffba_pkg::S_F_CLEAR;
        end else begin
          mem_wdata  = {size_cur, 1'b0};
          state_next = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_F_CLEAR: begin
        mem_we     = 1'b1;
        mem_wdata  = '0;
        state_next = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffba_pkg::S_IDLE;
      end
    endcase
  end

  // A failed request never reports an offset.
  a_fail_zero_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ffba_pkg::ST_OK |-> granted_offset == '0)
    else $error("failed request carries a nonzero offset");

  // The header store is only written while a request is being worked on.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state != ffba_pkg::S_IDLE && state != ffba_pkg::S_DONE)
    else $error("header write outside of a request");

  // An accepted beat starts a walk from the first block.
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=>
      (state == ffba_pkg::S_A_EVAL || state == ffba_pkg::S_F_EVAL) && cur == '0)
    else $error("accepted beat did not start a header walk");

  // The walk pointer stays inside the heap while headers are evaluated.
  a_cur_in_heap: assert property (@(posedge clk) disable iff (rst)
    state == ffba_pkg::S_A_EVAL || state == ffba_pkg::S_F_EVAL |-> cur < NG_G)
    else $error("walk pointer ran past the heap");

endmodule

`default_nettype wire
